// ===== rtl/median_distance_select_unit_assert.svh =====
// assertion macros shared by the rtl files
`ifndef MEDIAN_DISTANCE_SELECT_UNIT_ASSERT_SVH
`define MEDIAN_DISTANCE_SELECT_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define MDS_ASSERT_IMPL(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define MDS_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/mds_pkg.sv =====
`timescale 1ns / 1ps
package mds_pkg;
    localparam int MaxPoints  = 1024;
    localparam int CoordWidth = 16;

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_CMP   = 6'b001000,
        ST_NEXT  = 6'b010000,
        ST_OUT   = 6'b100000
    } mds_state_t;

    // controller to datapath
    typedef struct packed {
        logic store_pt;   // write squared distance at fill count
        logic drop_pt;    // mark overflow
        logic cand_load;  // register candidate read data
        logic cnt_clear;  // clear below/upto counts
        logic cnt_acc;    // accumulate compare of read data
        logic set_done;   // clear fill count and overflow
    } mds_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic few;      // fewer than two points
        logic hit;      // candidate has the requested rank
    } mds_stat_t;
endpackage

// ===== rtl/mds_ram.sv =====
`timescale 1ns / 1ps
module mds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== rtl/mds_datapath.sv =====
`timescale 1ns / 1ps
module mds_datapath #(
    parameter int MAX_POINTS  = mds_pkg::MaxPoints,
    parameter int COORD_WIDTH = mds_pkg::CoordWidth
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [15:0]       x_coord,
    input  logic [15:0]       y_coord,
    input  mds_pkg::mds_cmd_t cmd,
    input  logic [$clog2(MAX_POINTS)-1:0] rd_addr,
    input  logic [$clog2(MAX_POINTS):0]   scan_idx,
    output mds_pkg::mds_stat_t stat,
    output logic [$clog2(MAX_POINTS):0]   count,
    output logic [31:0]       cand,
    output logic              ovf
);
    import mds_pkg::*;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 1;
    localparam int PW = 2 * COORD_WIDTH;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] below_reg, below_next, upto_reg, upto_next;
    logic [31:0]   cand_reg;
    logic [31:0]   rd_data;
    logic [COORD_WIDTH-1:0] xv, yv;
    logic [COORD_WIDTH-1:0] ax, ay;
    logic [PW-1:0] px, py;
    logic [PW:0]   sq;
    logic [63:0]   sq_wide;
    logic [31:0]   dist_sq;
    logic [CW-1:0] rank_k;

    // magnitude of low bits of each coordinate, then square sum
    assign xv      = COORD_WIDTH'($signed(x_coord));
    assign yv      = COORD_WIDTH'($signed(y_coord));
    assign ax      = xv[COORD_WIDTH-1] ? (~xv + 1'b1) : xv;
    assign ay      = yv[COORD_WIDTH-1] ? (~yv + 1'b1) : yv;
    assign px      = PW'(ax) * PW'(ax);
    assign py      = PW'(ay) * PW'(ay);
    assign sq      = (PW+1)'(px) + (PW+1)'(py);
    assign sq_wide = 64'(sq);

    // saturate to 32 bits for wide coordinates
    assign dist_sq = (sq_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sq_wide[31:0];

    mds_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram (
        .aclk   (aclk),
        .wr_en  (cmd.store_pt),
        .wr_addr(count_reg[AW-1:0]),
        .wr_data(dist_sq),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // fill count and overflow flag
    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.store_pt) count_next = count_reg + 1'b1;
        if (cmd.drop_pt)  ovf_next = 1'b1;
        if (cmd.set_done) begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    // rank counters for the current candidate
    always_comb begin
        below_next = below_reg;
        upto_next  = upto_reg;
        if (cmd.cnt_clear) begin
            below_next = '0;
            upto_next  = '0;
        end else if (cmd.cnt_acc) begin
            below_next = below_reg + CW'(rd_data < cand_reg);
            upto_next  = upto_reg + CW'(rd_data <= cand_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            below_reg <= '0;
            upto_reg  <= '0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            below_reg <= below_next;
            upto_reg  <= upto_next;
        end
        if (cmd.cand_load) cand_reg <= rd_data;
    end

    assign rank_k    = count_reg >> 1;
    assign stat.full = (count_reg == CW'(MAX_POINTS));
    assign stat.few  = (rank_k == '0);
    assign stat.hit  = (below_reg < rank_k) && (rank_k <= upto_reg);
    assign count     = count_reg;
    assign cand      = cand_reg;
    assign ovf       = ovf_reg;

    `include "median_distance_select_unit_assert.svh"
    `MDS_ASSERT_IMPL(a_count_max, aclk, aresetn, 1'b1, count_reg <= CW'(MAX_POINTS),
        "fill count beyond capacity")
    `MDS_ASSERT_IMPL(a_upto_ge_below, aclk, aresetn, 1'b1, upto_reg >= below_reg,
        "rank counters out of order")
    `MDS_ASSERT_IMPL(a_no_store_full, aclk, aresetn, cmd.store_pt, !stat.full,
        "store written while full")
    `MDS_ASSERT_IMPL(a_scan_range, aclk, aresetn, cmd.cnt_acc, scan_idx <= count_reg,
        "scan index beyond fill")
endmodule

// ===== rtl/mds_ctrl.sv =====
`timescale 1ns / 1ps
module mds_ctrl #(
    parameter int MAX_POINTS = mds_pkg::MaxPoints
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  mds_pkg::mds_stat_t stat,
    input  logic [$clog2(MAX_POINTS):0] count,
    output mds_pkg::mds_cmd_t  cmd,
    output logic [$clog2(MAX_POINTS)-1:0] rd_addr,
    output logic [$clog2(MAX_POINTS):0]   scan_idx,
    output logic               sel_zero
);
    import mds_pkg::*;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 1;

    mds_state_t state_reg, state_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic          acc_reg, acc_next;
    logic          zero_reg, zero_next;
    logic          s_fire;

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_OUT);
    assign scan_idx = j_reg;
    assign sel_zero = zero_reg;

    // sequencing: load points, then for each candidate count over the store
    always_comb begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        acc_next      = 1'b0;
        zero_next     = zero_reg;
        cmd           = '0;
        rd_addr       = i_reg[AW-1:0];
        case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    cmd.store_pt = !stat.full;
                    cmd.drop_pt  = stat.full;
                    if (s_tlast) begin
                        state_next = ST_SCAN;
                        i_next     = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (stat.few) begin
                    zero_next  = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    zero_next  = 1'b0;
                    rd_addr    = i_reg[AW-1:0];
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.cand_load = 1'b1;
                cmd.cnt_clear = 1'b1;
                j_next        = '0;
                rd_addr       = '0;
                state_next    = ST_CMP;
            end
            ST_CMP: begin
                // rd_data holds entry j-1 when acc_reg set
                cmd.cnt_acc = acc_reg;
                rd_addr     = j_reg[AW-1:0];
                if (j_reg == count) begin
                    state_next = ST_NEXT;
                end else begin
                    acc_next = 1'b1;
                    j_next   = j_reg + 1'b1;
                end
                if (j_reg == '0) acc_next = 1'b1;
                if (j_reg == count) acc_next = 1'b0;
            end
            ST_NEXT: begin
                cmd.cnt_acc = acc_reg;
                if (!acc_reg) begin
                    if (stat.hit || (i_reg + 1'b1 == count)) begin
                        state_next = ST_OUT;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        rd_addr    = i_next[AW-1:0];
                        state_next = ST_READ;
                    end
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    cmd.set_done = 1'b1;
                    state_next   = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            acc_reg   <= 1'b0;
            zero_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            zero_reg  <= zero_next;
        end
        i_reg <= i_next;
        j_reg <= j_next;
    end

    `include "median_distance_select_unit_assert.svh"
    `MDS_ASSERT_IMPL(a_onehot, aclk, aresetn, 1'b1, $onehot(state_reg),
        "state not one-hot")
    `MDS_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, m_tvalid, !s_tready,
        "input taken while result pending")
    `MDS_ASSERT_NEXT(a_done_to_load, aclk, aresetn, m_tvalid && m_tready,
        state_reg == ST_LOAD, "no return to load after result")
endmodule

// ===== rtl/median_distance_select_unit.sv =====
`timescale 1ns / 1ps
// median distance select unit
// s_ channel: one point per transaction (x, y coordinates, tlast ends the set).
// Each point's squared distance is written into a store RAM, so points load
// at one per cycle while the unit is in its load phase. The transaction with
// tlast starts a selection walk: for each candidate entry i the whole set of
// n points is read through the single RAM read port and counted, for up to n
// candidates.
// m_ channel: one result per set, tdata = distance_sq, tuser = {overflow,
// no_rank}. With fewer than two points the result is 0 with no_rank set.
// Points beyond MAX_POINTS are dropped and flag overflow.
// While a result waits (receiver stalls) no new point is taken; the set state
// clears when the result transaction completes.
// Reset: synchronous active-low aresetn empties the set; no clearing pass.
module median_distance_select_unit #(
    parameter int MAX_POINTS  = mds_pkg::MaxPoints,
    parameter int COORD_WIDTH = mds_pkg::CoordWidth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] x_coord, [31:16] y_coord
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] distance_sq
    output logic [1:0]  m_tuser    // [0] no_rank, [1] overflow
);
    import mds_pkg::*;
    localparam int AW = $clog2(MAX_POINTS);

    mds_cmd_t  cmd;
    mds_stat_t stat;
    logic [AW-1:0] rd_addr;
    logic [AW:0]   scan_idx, count;
    logic [31:0]   cand;
    logic          ovf, sel_zero;

    mds_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tlast, .m_tvalid, .m_tready,
        .stat, .count, .cmd, .rd_addr, .scan_idx, .sel_zero
    );

    mds_datapath #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_dp (
        .aclk, .aresetn,
        .x_coord(s_tdata[15:0]), .y_coord(s_tdata[31:16]),
        .cmd, .rd_addr, .scan_idx, .stat, .count, .cand, .ovf
    );

    assign m_tdata = sel_zero ? 32'd0 : cand;
    assign m_tuser = {ovf, sel_zero};
endmodule
